FILE: rtl/core/lrupr_pkg.sv
package lrupr_pkg;

    // table geometry
    localparam int MAX_FRAMES = 16;
    localparam int PAGE_BITS  = 10;
    localparam int FRAME_BITS = $clog2(MAX_FRAMES);
    localparam int CNT_BITS   = $clog2(MAX_FRAMES + 1);
    localparam int CFG_BITS   = 5;
    localparam int FAULT_BITS = 32;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } t_state;

    // request broadcast to every cell during the scan
    typedef struct packed {
        logic [PAGE_BITS-1:0] page;
        logic [CNT_BITS-1:0]  valid;
    } t_search;

    // running search result handed from cell to cell
    typedef struct packed {
        logic                  hit;
        logic [FRAME_BITS-1:0] hit_idx;
        logic [FRAME_BITS-1:0] hit_rank;
        logic                  vic_any;
        logic [FRAME_BITS-1:0] vic_idx;
        logic [FRAME_BITS-1:0] vic_rank;
    } t_carry;

    // table update broadcast once per request
    typedef struct packed {
        logic                  upd;
        logic                  clr;
        logic                  wr;
        logic [FRAME_BITS-1:0] target;
        logic [CNT_BITS-1:0]   limit;
        logic [CNT_BITS-1:0]   valid;
    } t_cmd;

    localparam t_carry CARRY_INIT = '0;

endpackage

FILE: rtl/core/lrupr_cell.sv
module lrupr_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [lrupr_pkg::FRAME_BITS-1:0] i_index,
    input  lrupr_pkg::t_search              i_search,
    input  lrupr_pkg::t_cmd                 i_cmd,
    input  lrupr_pkg::t_carry               i_carry,
    output lrupr_pkg::t_carry               o_carry
);

    logic [lrupr_pkg::PAGE_BITS-1:0]  r_page;
    logic [lrupr_pkg::FRAME_BITS-1:0] r_rank;
    lrupr_pkg::t_carry                r_carry;
    lrupr_pkg::t_carry                n_carry;

    logic w_search_active;
    logic w_match;
    logic w_upd_active;
    logic w_target;
    logic w_age;

    // frame takes part only below the number of valid frames
    assign w_search_active = lrupr_pkg::CNT_BITS'(i_index) < i_search.valid;
    assign w_match         = w_search_active && (r_page == i_search.page);

    // fold this frame into the running first-hit and oldest-frame result
    always_comb begin
        n_carry = i_carry;
        if (!i_carry.hit && w_match) begin
            n_carry.hit      = 1'b1;
            n_carry.hit_idx  = i_index;
            n_carry.hit_rank = r_rank;
        end
        if (w_search_active && (!i_carry.vic_any || (r_rank > i_carry.vic_rank))) begin
            n_carry.vic_any  = 1'b1;
            n_carry.vic_idx  = i_index;
            n_carry.vic_rank = r_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        r_carry <= n_carry;
    end

    assign o_carry = r_carry;

    // recency update: target becomes newest, younger frames age by one
    assign w_upd_active = lrupr_pkg::CNT_BITS'(i_index) < i_cmd.valid;
    assign w_target     = (i_index == i_cmd.target);
    assign w_age        = w_upd_active
                       && (lrupr_pkg::CNT_BITS'(r_rank) < i_cmd.limit)
                       && (lrupr_pkg::CNT_BITS'(r_rank)
                           < lrupr_pkg::CNT_BITS'(lrupr_pkg::MAX_FRAMES - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank <= '0;
        end else if (i_cmd.clr) begin
            r_rank <= '0;
        end else if (i_cmd.upd) begin
            if (w_target) begin
                r_rank <= '0;
            end else if (w_age) begin
                r_rank <= r_rank + lrupr_pkg::FRAME_BITS'(1);
            end
        end
    end

    // page store, written on fill or replacement only
    always_ff @(posedge i_clk) begin
        if (i_cmd.upd && i_cmd.wr && w_target) begin
            r_page <= i_search.page;
        end
    end

endmodule

FILE: rtl/core/lru_page_replacement.sv
// LRU page replacement table built as a row of frame cells.
//
// Request channel: i_valid / o_ready carry i_page_number and i_last_reference.
// Result channel: o_valid / i_ready carry o_page_hit, o_frame_used,
// o_fault_total and o_string_done, one result per request.
// Configuration: i_cfg_wr_en writes i_cfg_wr_data into frames_in_use at once.
//
// A request is taken only while the controller is idle. The search result
// ripples through the row one cell per clock, so a scan lasts as long as the
// row is long and is followed by the update state, in which the result is
// registered. A new request can be taken only once the controller is back in
// idle, so the block finishes one request before it takes the next.
// The result sits in an output register, so the next request is accepted
// and scanned while an earlier result waits; if that result is still not
// taken when the update is due, the controller holds in the update cycle.
// A request flagged last reference empties the table and zeroes the fault
// count after its result is formed.
// Reset (synchronous, active low) empties the table, zeroes the fault count
// and sets frames_in_use to 3.
module lru_page_replacement (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [lrupr_pkg::CFG_BITS-1:0]       i_cfg_wr_data,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [lrupr_pkg::PAGE_BITS-1:0]      i_page_number,
    input  logic                                 i_last_reference,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic                                 o_page_hit,
    output logic [lrupr_pkg::FRAME_BITS-1:0]     o_frame_used,
    output logic [lrupr_pkg::FAULT_BITS-1:0]     o_fault_total,
    output logic                                 o_string_done
);

    lrupr_pkg::t_state r_state;
    lrupr_pkg::t_state n_state;

    logic [lrupr_pkg::CFG_BITS-1:0]   r_frames_in_use;
    logic [lrupr_pkg::PAGE_BITS-1:0]  r_page;
    logic                             r_last;
    logic [lrupr_pkg::FRAME_BITS-1:0] r_scan_cnt;
    logic [lrupr_pkg::CNT_BITS-1:0]   r_filled;
    logic [lrupr_pkg::FAULT_BITS-1:0] r_fault;

    logic                             r_out_valid;
    logic                             r_out_hit;
    logic [lrupr_pkg::FRAME_BITS-1:0] r_out_frame;
    logic [lrupr_pkg::FAULT_BITS-1:0] r_out_fault;
    logic                             r_out_done;

    logic [lrupr_pkg::CNT_BITS-1:0]   w_fc;
    logic [lrupr_pkg::CNT_BITS-1:0]   w_valid;
    logic                             w_fill;
    logic                             w_accept;
    logic                             w_out_free;
    logic                             w_scan_end;
    logic                             w_commit;
    logic [lrupr_pkg::FAULT_BITS-1:0] w_fault_next;
    logic [lrupr_pkg::FRAME_BITS-1:0] w_frame;

    lrupr_pkg::t_search w_search;
    lrupr_pkg::t_cmd    w_cmd;
    lrupr_pkg::t_carry  w_chain [lrupr_pkg::MAX_FRAMES+1];
    lrupr_pkg::t_carry  w_final;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_in_use <= lrupr_pkg::CFG_BITS'(3);
        end else if (i_cfg_wr_en) begin
            r_frames_in_use <= i_cfg_wr_data;
        end
    end

    // frame count clamped to one through the table size, and frames currently valid
    always_comb begin
        if (r_frames_in_use == '0) begin
            w_fc = lrupr_pkg::CNT_BITS'(1);
        end else if (int'(r_frames_in_use) > lrupr_pkg::MAX_FRAMES) begin
            w_fc = lrupr_pkg::CNT_BITS'(lrupr_pkg::MAX_FRAMES);
        end else begin
            w_fc = lrupr_pkg::CNT_BITS'(r_frames_in_use);
        end
    end

    assign w_valid = (r_filled < w_fc) ? r_filled : w_fc;
    assign w_fill  = (r_filled < w_fc);

    // handshake conditions
    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;
    assign w_scan_end = (r_scan_cnt == lrupr_pkg::FRAME_BITS'(lrupr_pkg::MAX_FRAMES - 1));
    assign w_commit   = (r_state == lrupr_pkg::ST_UPDATE) && w_out_free;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lrupr_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = lrupr_pkg::ST_SCAN;
                end
            end
            lrupr_pkg::ST_SCAN: begin
                if (w_scan_end) begin
                    n_state = lrupr_pkg::ST_UPDATE;
                end
            end
            lrupr_pkg::ST_UPDATE: begin
                if (w_out_free) begin
                    n_state = lrupr_pkg::ST_IDLE;
                end
            end
            default: n_state = lrupr_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        unique case (r_state)
            lrupr_pkg::ST_IDLE:   o_ready = 1'b1;
            lrupr_pkg::ST_SCAN:   o_ready = 1'b0;
            lrupr_pkg::ST_UPDATE: o_ready = 1'b0;
            default:              o_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lrupr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // request capture and scan counter
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_page <= i_page_number;
            r_last <= i_last_reference;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_cnt <= '0;
        end else if (w_accept) begin
            r_scan_cnt <= '0;
        end else if (r_state == lrupr_pkg::ST_SCAN) begin
            r_scan_cnt <= r_scan_cnt + lrupr_pkg::FRAME_BITS'(1);
        end
    end

    // row of frame cells
    assign w_search.page  = r_page;
    assign w_search.valid = w_valid;
    assign w_chain[0]     = lrupr_pkg::CARRY_INIT;

    for (genvar g = 0; g < lrupr_pkg::MAX_FRAMES; g++) begin : g_cell
        lrupr_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_index  (lrupr_pkg::FRAME_BITS'(g)),
            .i_search (w_search),
            .i_cmd    (w_cmd),
            .i_carry  (w_chain[g]),
            .o_carry  (w_chain[g+1])
        );
    end

    assign w_final = w_chain[lrupr_pkg::MAX_FRAMES];

    // decision from the end of the row
    always_comb begin
        if (w_final.hit || (r_fault == '1)) begin
            w_fault_next = r_fault;
        end else begin
            w_fault_next = r_fault + lrupr_pkg::FAULT_BITS'(1);
        end

        w_cmd.upd   = w_commit;
        w_cmd.clr   = w_commit && r_last;
        w_cmd.wr    = !w_final.hit;
        w_cmd.valid = w_valid;
        if (w_final.hit) begin
            w_frame     = w_final.hit_idx;
            w_cmd.limit = lrupr_pkg::CNT_BITS'(w_final.hit_rank);
        end else if (w_fill) begin
            w_frame     = r_filled[lrupr_pkg::FRAME_BITS-1:0];
            w_cmd.limit = lrupr_pkg::CNT_BITS'(lrupr_pkg::MAX_FRAMES);
        end else begin
            w_frame     = w_final.vic_idx;
            w_cmd.limit = lrupr_pkg::CNT_BITS'(w_final.vic_rank);
        end
        w_cmd.target = w_frame;
    end

    // fill count and fault count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled <= '0;
            r_fault  <= '0;
        end else if (w_commit) begin
            if (r_last) begin
                r_filled <= '0;
                r_fault  <= '0;
            end else begin
                r_fault <= w_fault_next;
                if (!w_final.hit && w_fill) begin
                    r_filled <= r_filled + lrupr_pkg::CNT_BITS'(1);
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_hit   <= w_final.hit;
            r_out_frame <= w_frame;
            r_out_fault <= w_fault_next;
            r_out_done  <= r_last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_page_hit    = r_out_hit;
    assign o_frame_used  = r_out_frame;
    assign o_fault_total = r_out_fault;
    assign o_string_done = r_out_done;

    // checks
    a_filled_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_filled) <= lrupr_pkg::MAX_FRAMES)
        else $error("fill count beyond table size");

    a_miss_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_page_hit) |-> (o_fault_total != '0))
        else $error("page fault reported with zero fault total");

    a_hold_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lrupr_pkg::ST_UPDATE && r_out_valid && !i_ready)
            |=> (r_state == lrupr_pkg::ST_UPDATE && o_valid))
        else $error("update committed over an untaken result");

    a_scan_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept) |=> (r_state == lrupr_pkg::ST_SCAN && r_scan_cnt == '0))
        else $error("scan did not start after request");

endmodule

FILE: test/lru_page_replacement_tb.sv
`timescale 1ns / 1ps

// one predicted outcome of a page request
typedef struct packed {
    logic                             hit;
    logic [lrupr_pkg::FRAME_BITS-1:0] frame;
    logic [lrupr_pkg::FAULT_BITS-1:0] faults;
    logic                             done;
} t_page_outcome;

// mirror of the replacement table plus the queue of outcomes still owed
class lru_scoreboard;
    logic [lrupr_pkg::PAGE_BITS-1:0]  page_tab [lrupr_pkg::MAX_FRAMES];
    int unsigned                      rank_tab [lrupr_pkg::MAX_FRAMES];
    int unsigned                      filled;
    logic [lrupr_pkg::FAULT_BITS-1:0] faults;
    logic [lrupr_pkg::CFG_BITS-1:0]   frames_cfg;
    t_page_outcome                    owed_outcomes [$];
    int unsigned                      errors;
    int unsigned                      results_seen;

    function new();
        clear_table();
        frames_cfg   = 5'd3;
        errors       = 0;
        results_seen = 0;
    endfunction

    function void clear_table();
        int unsigned i;
        for (i = 0; i < lrupr_pkg::MAX_FRAMES; i++) begin
            page_tab[i] = '0;
            rank_tab[i] = 0;
        end
        filled = 0;
        faults = '0;
    endfunction

    function void set_frames(logic [lrupr_pkg::CFG_BITS-1:0] value);
        frames_cfg = value;
    endfunction

    function int unsigned outstanding();
        return owed_outcomes.size();
    endfunction

    // frames younger than the limit move one step older, capped at the oldest rank
    function void age_ranks(int unsigned count, int unsigned limit);
        int unsigned i;
        for (i = 0; i < count && i < lrupr_pkg::MAX_FRAMES; i++) begin
            if (rank_tab[i] < limit && rank_tab[i] < lrupr_pkg::MAX_FRAMES - 1)
                rank_tab[i]++;
        end
    endfunction

    function t_page_outcome predict_reference(logic [lrupr_pkg::PAGE_BITS-1:0] page,
                                              logic last);
        t_page_outcome res;
        int unsigned   span;
        int unsigned   live;
        int unsigned   idx;
        int unsigned   victim;
        int unsigned   i;
        bit            found;
        // zero counts as one frame, anything past the table as the whole table
        span = (frames_cfg == 0) ? 1 :
               (frames_cfg > lrupr_pkg::MAX_FRAMES) ? lrupr_pkg::MAX_FRAMES : frames_cfg;
        live = (filled < span) ? filled : span;
        found = 1'b0;
        idx = 0;
        for (i = 0; i < live; i++) begin
            if (!found && page_tab[i] == page) begin
                found = 1'b1;
                idx = i;
            end
        end
        if (found) begin
            age_ranks(live, rank_tab[idx]);
            rank_tab[idx] = 0;
        end else begin
            if (faults != '1)
                faults++;
            if (filled < span) begin
                // next empty frame
                idx = filled;
                age_ranks(live, lrupr_pkg::MAX_FRAMES);
                filled++;
            end else begin
                // oldest frame, lowest index on a tie
                victim = 0;
                for (i = 1; i < live; i++) begin
                    if (rank_tab[i] > rank_tab[victim])
                        victim = i;
                end
                idx = victim;
                age_ranks(live, rank_tab[idx]);
            end
            page_tab[idx] = page;
            rank_tab[idx] = 0;
        end
        res.hit    = found;
        res.frame  = lrupr_pkg::FRAME_BITS'(idx);
        res.faults = faults;
        res.done   = last;
        if (last)
            clear_table();
        return res;
    endfunction

    function void note_reference(logic [lrupr_pkg::PAGE_BITS-1:0] page, logic last);
        owed_outcomes.push_back(predict_reference(page, last));
    endfunction

    function void check_outcome(logic hit, logic [lrupr_pkg::FRAME_BITS-1:0] frame,
                                logic [lrupr_pkg::FAULT_BITS-1:0] total, logic done);
        t_page_outcome want;
        results_seen++;
        if (owed_outcomes.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("result %0d with no request outstanding:", results_seen,
                         " hit=%0b frame=%0d faults=%0d done=%0b",
                         hit, frame, total, done);
            return;
        end
        want = owed_outcomes.pop_front();
        if (want.hit !== hit || want.frame !== frame || want.faults !== total ||
            want.done !== done) begin
            errors++;
            if (errors <= 10)
                $display("mismatch on result %0d:", results_seen,
                         " expected hit=%0b frame=%0d faults=%0d done=%0b,",
                         want.hit, want.frame, want.faults, want.done,
                         " got hit=%0b frame=%0d faults=%0d done=%0b",
                         hit, frame, total, done);
        end
    endfunction
endclass

module lru_page_replacement_tb;

    typedef enum int {
        SINK_FREE,
        SINK_RANDOM,
        SINK_PERIODIC,
        SINK_SLOW
    } t_sink_mode;

    logic                             i_clk            = 1'b0;
    logic                             i_rst_n          = 1'b0;
    logic                             i_cfg_wr_en      = 1'b0;
    logic [lrupr_pkg::CFG_BITS-1:0]   i_cfg_wr_data    = 5'd3;
    logic                             i_valid          = 1'b0;
    logic [lrupr_pkg::PAGE_BITS-1:0]  i_page_number    = '0;
    logic                             i_last_reference = 1'b0;
    logic                             i_ready          = 1'b0;
    logic                             o_ready;
    logic                             o_valid;
    logic                             o_page_hit;
    logic [lrupr_pkg::FRAME_BITS-1:0] o_frame_used;
    logic [lrupr_pkg::FAULT_BITS-1:0] o_fault_total;
    logic                             o_string_done;

    lru_scoreboard sb = new();

    bit          hold_off_req = 1'b0;
    bit          gaps_on      = 1'b0;
    int unsigned gap_max      = 1;
    int unsigned burst_left   = 0;

    lru_page_replacement u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_page_number    (i_page_number),
        .i_last_reference (i_last_reference),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_page_hit       (o_page_hit),
        .o_frame_used     (o_frame_used),
        .o_fault_total    (o_fault_total),
        .o_string_done    (o_string_done)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // handshakes sampled at the rising edge; results checked before new requests are noted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready)
                sb.check_outcome(o_page_hit, o_frame_used, o_fault_total, o_string_done);
            if (i_valid && o_ready)
                sb.note_reference(i_page_number, i_last_reference);
        end
    end

    // result sink: changing stall pattern, with a long hold-off on demand
    initial begin : result_sink
        t_sink_mode  mode;
        int unsigned mode_left;
        int unsigned tick;
        int unsigned hold_left;
        mode      = SINK_FREE;
        mode_left = 0;
        tick      = 0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            tick++;
            if (mode_left == 0) begin
                mode      = t_sink_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            if (hold_off_req && hold_left == 0) begin
                hold_left    = 400;
                hold_off_req = 1'b0;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                case (mode)
                    SINK_FREE:     i_ready <= 1'b1;
                    SINK_RANDOM:   i_ready <= ($urandom_range(0, 3) != 0);
                    SINK_PERIODIC: i_ready <= ((tick % 7) >= 3);
                    default:       i_ready <= ($urandom_range(0, 15) < 3);
                endcase
            end
        end
    end

    // offer one request from a falling edge, return at a falling edge once taken
    task automatic send_request(input logic [lrupr_pkg::PAGE_BITS-1:0] page,
                                input logic last);
        i_valid          <= 1'b1;
        i_page_number    <= page;
        i_last_reference <= last;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        if (gaps_on) begin
            if (burst_left == 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(negedge i_clk);
                burst_left = $urandom_range(1, 8);
            end else begin
                burst_left--;
            end
        end
    endtask

    // frame count changes only once every result is home and the block is idle
    task automatic write_frames(input logic [lrupr_pkg::CFG_BITS-1:0] value);
        i_valid <= 1'b0;
        while (sb.outstanding() != 0 || !o_ready)
            @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.set_frames(value);
    endtask

    // overall time limit
    initial begin : watchdog
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [lrupr_pkg::CFG_BITS-1:0]  corners [8];
        logic [lrupr_pkg::PAGE_BITS-1:0] pool [20];
        logic [lrupr_pkg::CFG_BITS-1:0]  cfg;
        logic [lrupr_pkg::PAGE_BITS-1:0] page;
        logic                            last;
        int unsigned                     ph;
        int unsigned                     n;
        int unsigned                     k;
        int unsigned                     str_len;
        int unsigned                     pool_n;
        int unsigned                     span;

        corners = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd17, 5'd2, 5'd15, 5'd8};

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: fill, hit, replace with the reset frame count of three
        gaps_on = 1'b0;
        send_request(10'd0, 1'b0);
        send_request(10'd1023, 1'b0);
        send_request(10'd0, 1'b0);
        send_request(10'd512, 1'b0);
        send_request(10'd1023, 1'b0);
        send_request(10'd7, 1'b0);
        send_request(10'd512, 1'b0);
        send_request(10'd0, 1'b0);
        send_request(10'd7, 1'b1);
        // emptied table must not match page zero
        send_request(10'd0, 1'b0);
        send_request(10'd0, 1'b1);
        // zero frames behaves as one
        write_frames(5'd0);
        send_request(10'd5, 1'b0);
        send_request(10'd5, 1'b0);
        send_request(10'd6, 1'b0);
        send_request(10'd6, 1'b1);
        // frame count lowered in the middle of a string
        write_frames(5'd4);
        send_request(10'd1, 1'b0);
        send_request(10'd2, 1'b0);
        send_request(10'd3, 1'b0);
        write_frames(5'd2);
        send_request(10'd3, 1'b0);
        send_request(10'd2, 1'b0);
        send_request(10'd9, 1'b1);
        // oversized frame count
        write_frames(5'd31);
        send_request(10'd341, 1'b0);
        send_request(10'd682, 1'b0);
        send_request(10'd682, 1'b1);

        // random strings drawn mostly from a small page pool
        for (ph = 0; ph < 12; ph++) begin
            cfg = (ph < 8) ? corners[ph] : lrupr_pkg::CFG_BITS'($urandom_range(0, 31));
            write_frames(cfg);
            gaps_on    = ((ph % 4) != 1);
            gap_max    = $urandom_range(2, 40);
            burst_left = $urandom_range(1, 8);
            if (ph == 2 || ph == 7)
                hold_off_req = 1'b1;
            span = (cfg == 0) ? 1 :
                   (cfg > lrupr_pkg::MAX_FRAMES) ? lrupr_pkg::MAX_FRAMES : cfg;
            n = 0;
            while (n < 150) begin
                str_len = $urandom_range(1, 60);
                pool_n  = span + $urandom_range(0, 3);
                if (pool_n > 20)
                    pool_n = 20;
                for (k = 0; k < pool_n; k++)
                    pool[k] = lrupr_pkg::PAGE_BITS'($urandom_range(0, 1023));
                for (k = 0; k < str_len && n < 150; k++) begin
                    if ($urandom_range(0, 99) < 88)
                        page = pool[$urandom_range(0, pool_n - 1)];
                    else
                        page = lrupr_pkg::PAGE_BITS'($urandom_range(0, 1023));
                    last = (k == str_len - 1) || ($urandom_range(0, 99) < 2);
                    send_request(page, last);
                    n++;
                end
            end
        end

        // drain
        i_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
